>>> hw/rtl/ere_pkg.sv
// ============================================================================
// Ultrasonic echo ranger package
// Shared widths, reset values, register indexes and the types that pass
// between the controller, the datapath and the ports.
// ============================================================================
package ere_pkg;

    // Field widths fixed by the interface.
    localparam int CH_W    = 2;
    localparam int TIME_W  = 32;
    localparam int DIST_W  = 16;
    localparam int SPEED_W = 16;
    localparam int ALPHA_W = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Shared multiplier operand and product widths.
    localparam int MUL_A_W = 32;
    localparam int MUL_B_W = 16;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // Blend accumulator: reading*a + old*(256-a) + 128 fits in 24 bits.
    localparam int ACC_W = 24;

    localparam int NUM_SENSORS_DEFAULT = 3;

    // Register reset values.
    localparam logic [SPEED_W-1:0] HALF_SPEED_RESET = 16'd11239;
    localparam logic [DIST_W-1:0]  MAX_RANGE_RESET  = 16'd4000;
    localparam logic [ALPHA_W-1:0] ALPHA_RESET      = 9'd128;
    localparam logic [ALPHA_W-1:0] ALPHA_ONE        = 9'd256;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_HALF_SPEED = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_RANGE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA      = 2'd2;

    // One echo edge request.
    typedef struct packed {
        logic [CH_W-1:0]   channel;
        logic [TIME_W-1:0] time_us;
    } ere_in_t;

    // One result request.
    typedef struct packed {
        logic [CH_W-1:0]   sensor;
        logic [DIST_W-1:0] distance_mm;
        logic              measured;
        logic              accepted;
    } ere_out_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;    // take the input request
        logic arm_emit;   // arm the channel (if valid) and emit the result
        logic scale;      // elapsed time times half speed
        logic round;      // round, saturate and range check the reading
        logic mix_new;    // reading times alpha
        logic mix_old;    // old filter value times (1 - alpha), accumulate
        logic meas_emit;  // disarm, update the filter and emit the result
    } ere_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic ch_valid;   // captured channel exists
        logic armed;      // captured channel is armed
        logic out_free;   // output register can take a result this cycle
    } ere_status_t;

endpackage

>>> hw/rtl/ultrasonic_echo_ranger.sv
// ============================================================================
// Ultrasonic echo ranger
// Echo-edge time-of-flight measurement with a per-channel moving average.
// ============================================================================
// Each input request is one echo-pin edge with its channel and microsecond
// timestamp, and each gives exactly one result request. An edge on an idle
// channel arms it; the next edge on that channel measures the elapsed time,
// scales it to millimetres, range checks it and blends it into the channel's
// filtered distance. An arming edge, or an edge on a channel beyond the
// sensor count, has its result registered in the decode state, which waits
// for a free output register. A measuring edge has its result registered in
// the finish state, after the decode, scale, round, mix-new and mix-old
// states. A new request is accepted only once the previous one has returned
// the controller to idle. The single shared 32x16 multiplier is used three
// times in sequence (scaling, new-reading weight, old-value weight) between
// the decode, rounding and final update steps. A result waiting in the output
// register does not block the next request; only a second result waiting
// behind it stalls the block. No clearing pass follows reset.
module ultrasonic_echo_ranger #(
    parameter int NUM_SENSORS = ere_pkg::NUM_SENSORS_DEFAULT
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [ere_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ere_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  ere_pkg::ere_in_t                s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output ere_pkg::ere_out_t               m_data
);
    import ere_pkg::*;

    ere_cmd_t    cmd;
    ere_status_t status;

    // Sequencer.
    ere_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // Arithmetic, state and output register.
    ere_datapath #(
        .NUM_SENSORS (NUM_SENSORS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_data    (s_data),
        .cmd       (cmd),
        .status    (status),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

>>> hw/rtl/ere_ctrl.sv
// ============================================================================
// Ultrasonic echo ranger controller
// Sequences each echo edge through decode and, for a measuring edge, scaling,
// range check and the moving average blend, issuing one command group per cycle.
// ============================================================================
module ere_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  ere_pkg::ere_status_t status,
    output ere_pkg::ere_cmd_t    cmd
);
    import ere_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SCALE,
        S_ROUND,
        S_MIX_NEW,
        S_MIX_OLD,
        S_FINISH
    } state_t;

    state_t state_reg;

    // Input is taken only between requests.
    assign s_ready = (state_reg == S_IDLE);

    // Command decode from the current state and datapath status.
    always_comb begin
        cmd = '0;
        case (state_reg)
            S_IDLE: begin
                cmd.capture = s_valid;
            end
            S_DECODE: begin
                cmd.arm_emit = (!status.ch_valid || !status.armed) && status.out_free;
            end
            S_SCALE: begin
                cmd.scale = 1'b1;
            end
            S_ROUND: begin
                cmd.round = 1'b1;
            end
            S_MIX_NEW: begin
                cmd.mix_new = 1'b1;
            end
            S_MIX_OLD: begin
                cmd.mix_old = 1'b1;
            end
            S_FINISH: begin
                cmd.meas_emit = status.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        state_reg <= S_DECODE;
                    end
                end
                S_DECODE: begin
                    if (status.ch_valid && status.armed) begin
                        state_reg <= S_SCALE;
                    end else if (status.out_free) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_SCALE:   state_reg <= S_ROUND;
                S_ROUND:   state_reg <= S_MIX_NEW;
                S_MIX_NEW: state_reg <= S_MIX_OLD;
                S_MIX_OLD: state_reg <= S_FINISH;
                S_FINISH: begin
                    if (status.out_free) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // A measurement only proceeds on an armed, existing channel.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DECODE && status.ch_valid && status.armed) |=> (state_reg == S_SCALE))
        else $error("measurement did not start scaling");

    // A new request is never taken while a measurement is in flight.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_MIX_OLD) |=> !s_ready)
        else $error("input taken during blend");

    // Each taken request leads to decode.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.capture |=> (state_reg == S_DECODE))
        else $error("captured request not decoded");

endmodule

>>> hw/rtl/ere_datapath.sv
// ============================================================================
// Ultrasonic echo ranger datapath
// Holds the registers, per-channel state, the shared 32x16 multiplier and
// the output register; acts on the controller's commands.
// ============================================================================
module ere_datapath #(
    parameter int NUM_SENSORS = ere_pkg::NUM_SENSORS_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [ere_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ere_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  ere_pkg::ere_in_t                    s_data,
    input  ere_pkg::ere_cmd_t                   cmd,
    output ere_pkg::ere_status_t                status,
    output logic                                m_valid,
    input  logic                                m_ready,
    output ere_pkg::ere_out_t                   m_data
);
    import ere_pkg::*;

    // Configuration registers.
    logic [SPEED_W-1:0] half_speed_reg;
    logic [DIST_W-1:0]  max_range_reg;
    logic [ALPHA_W-1:0] alpha_reg;

    // Per-channel state.
    logic              armed_reg [NUM_SENSORS];
    logic [TIME_W-1:0] start_reg [NUM_SENSORS];
    logic [DIST_W-1:0] filt_reg  [NUM_SENSORS];

    // Working registers.
    ere_in_t           in_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [DIST_W-1:0] reading_reg;
    logic              in_range_reg;
    logic [ACC_W-1:0]  acc_reg;
    ere_out_t          out_reg;
    logic              m_valid_reg;
    logic              m_valid_next;

    // Combinational values.
    logic              ch_valid;
    logic              sel_armed;
    logic [TIME_W-1:0] sel_start;
    logic [DIST_W-1:0] sel_filt;
    logic [TIME_W-1:0] elapsed;
    logic [ALPHA_W-1:0] alpha_sat;
    logic [ALPHA_W-1:0] alpha_inv;
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [PROD_W-1:0]  mul_out;
    logic [PROD_W-1:0]  rounded;
    logic [DIST_W-1:0]  reading_sat;
    logic [DIST_W-1:0]  filt_new;
    logic               out_free;

    // Configuration writes; an unknown index is ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_speed_reg <= HALF_SPEED_RESET;
            max_range_reg  <= MAX_RANGE_RESET;
            alpha_reg      <= ALPHA_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_HALF_SPEED: half_speed_reg <= cfg_wdata[SPEED_W-1:0];
                REG_MAX_RANGE:  max_range_reg  <= cfg_wdata[DIST_W-1:0];
                REG_ALPHA:      alpha_reg      <= cfg_wdata[ALPHA_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Select the state of the captured channel.
    always_comb begin
        ch_valid  = (int'(in_reg.channel) < NUM_SENSORS);
        sel_armed = 1'b0;
        sel_start = '0;
        sel_filt  = '0;
        for (int i = 0; i < NUM_SENSORS; i++) begin
            if (int'(in_reg.channel) == i) begin
                sel_armed = armed_reg[i];
                sel_start = start_reg[i];
                sel_filt  = filt_reg[i];
            end
        end
    end

    // Elapsed time wraps modulo 2^32; alpha saturates at one.
    assign elapsed   = in_reg.time_us - sel_start;
    assign alpha_sat = (alpha_reg > ALPHA_ONE) ? ALPHA_ONE : alpha_reg;
    assign alpha_inv = ALPHA_ONE - alpha_sat;

    // Shared multiplier operand selection.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (cmd.scale) begin
            mul_a = elapsed;
            mul_b = half_speed_reg;
        end else if (cmd.mix_new) begin
            mul_a = MUL_A_W'(reading_reg);
            mul_b = MUL_B_W'(alpha_sat);
        end else if (cmd.mix_old) begin
            mul_a = MUL_A_W'(sel_filt);
            mul_b = MUL_B_W'(alpha_inv);
        end
    end

    assign mul_out = PROD_W'(mul_a) * PROD_W'(mul_b);

    // Round half up and saturate the scaled reading.
    assign rounded     = prod_reg + PROD_W'(32'h8000);
    assign reading_sat = (|rounded[PROD_W-1:DIST_W+16]) ? '1 : rounded[DIST_W+15:16];

    // Blended filter value, rounding already folded into the accumulator.
    assign filt_new = acc_reg[ACC_W-1:8];

    // Working registers.
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            in_reg <= s_data;
        end
        if (cmd.scale || cmd.mix_new) begin
            prod_reg <= mul_out;
        end
        if (cmd.round) begin
            reading_reg  <= reading_sat;
            in_range_reg <= (reading_sat <= max_range_reg);
        end
        if (cmd.mix_old) begin
            acc_reg <= prod_reg[ACC_W-1:0] + mul_out[ACC_W-1:0] + ACC_W'(128);
        end
    end

    // Per-channel state updates.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_SENSORS; i++) begin
                armed_reg[i] <= 1'b0;
                filt_reg[i]  <= '0;
            end
        end else begin
            for (int i = 0; i < NUM_SENSORS; i++) begin
                if (int'(in_reg.channel) == i) begin
                    if (cmd.arm_emit) begin
                        armed_reg[i] <= 1'b1;
                    end
                    if (cmd.meas_emit) begin
                        armed_reg[i] <= 1'b0;
                        if (in_range_reg) begin
                            filt_reg[i] <= filt_new;
                        end
                    end
                end
            end
        end
    end

    // Start stamps need no reset: they are read only while armed.
    always_ff @(posedge aclk) begin
        for (int i = 0; i < NUM_SENSORS; i++) begin
            if (cmd.arm_emit && int'(in_reg.channel) == i) begin
                start_reg[i] <= in_reg.time_us;
            end
        end
    end

    // Output register.
    assign out_free     = !m_valid_reg || m_ready;
    assign m_valid_next = cmd.arm_emit || cmd.meas_emit || (m_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.arm_emit) begin
            out_reg.sensor      <= in_reg.channel;
            out_reg.distance_mm <= ch_valid ? sel_filt : '0;
            out_reg.measured    <= 1'b0;
            out_reg.accepted    <= 1'b0;
        end else if (cmd.meas_emit) begin
            out_reg.sensor      <= in_reg.channel;
            out_reg.distance_mm <= in_range_reg ? filt_new : sel_filt;
            out_reg.measured    <= 1'b1;
            out_reg.accepted    <= in_range_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    assign status.ch_valid = ch_valid;
    assign status.armed    = sel_armed;
    assign status.out_free = out_free;

    // A result is written only into a free output register.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.arm_emit || cmd.meas_emit) |-> out_free)
        else $error("result overwrote a pending output");

    // A measurement completes only on an existing, armed channel.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.meas_emit |-> (ch_valid && sel_armed))
        else $error("measurement on unarmed channel");

    // An accepted reading always comes from a measuring edge.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (!out_reg.accepted || out_reg.measured))
        else $error("accepted without measurement");

    // A channel beyond the sensor count reports zero distance and no measurement.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && int'(out_reg.sensor) >= NUM_SENSORS)
            |-> (out_reg.distance_mm == '0 && !out_reg.measured))
        else $error("nonexistent channel produced a reading");

endmodule

>>> tb/sv/ultrasonic_echo_ranger_tb.sv
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger testbench
// Drives echo-edge requests into the ranger and checks every result request
// against a cycle-free model of the ranging and filtering held in this bench.
// A directed part covers the register extremes, timestamp wrap, a zero
// timestamp and the unused channel. Random phases follow, each under its own
// register setting, most with bursty requests and a stalling receiver.
// ----------------------------------------------------------------------------
module ultrasonic_echo_ranger_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ere_pkg::*;

    localparam int NSENS = NUM_SENSORS_DEFAULT;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam logic [CH_W-1:0] SPARE_CHANNEL = 2'd3;
    localparam int DRAIN_CYCLES = 16;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_PHASES = 13;
    localparam int EDGES_PER_PHASE = 150;

    logic aclk;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    ere_in_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    ere_out_t m_data;

    // Shadow of the ranger: registers and per-channel state.
    logic [SPEED_W-1:0] half_speed_cfg;
    logic [DIST_W-1:0] max_range_cfg;
    logic [ALPHA_W-1:0] alpha_cfg;
    bit armed_q [NSENS];
    logic [TIME_W-1:0] start_q [NSENS];
    logic [DIST_W-1:0] filtered_q [NSENS];

    // Last timestamp used per channel, so that random edges form pulses.
    logic [TIME_W-1:0] chan_stamp [NSENS];

    ere_out_t expected_results [$];
    int items_sent = 0;
    int results_checked = 0;
    int mismatches = 0;
    int config_writes = 0;
    int pulses_measured = 0;
    int readings_accepted = 0;
    int burst_left = 0;
    int cycle_count = 0;
    bit steady_flow = 1'b0;
    logic [9:0] stall_phase = '0;

    ultrasonic_echo_ranger #(
        .NUM_SENSORS(NSENS)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data(s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data(m_data)
    );

    // 12 ns clock.
    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    // Run limit.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results still pending.",
                     cycle_count, expected_results.size());
            $display("ultrasonic_echo_ranger_tb NOT OK");
            $finish;
        end
    end

    // Receiver stalls follow a pattern chosen by the upper bits of a free-running counter.
    always @(posedge aclk) begin
        stall_phase <= stall_phase + 1'b1;
        if (steady_flow) begin
            m_ready <= 1'b1;
        end else begin
            case (stall_phase[9:8])
                2'd0: m_ready <= 1'b1;
                2'd1: m_ready <= ($urandom_range(0, 1) == 0);
                2'd2: m_ready <= ($urandom_range(0, 3) == 0);
                default: m_ready <= (stall_phase[2:0] < 3'd3);
            endcase
        end
    end

    // Compare each result request with the oldest expectation.
    always @(posedge aclk) begin : check_results
        ere_out_t want;
        if (aresetn && m_valid && m_ready) begin
            results_checked++;
            if (expected_results.size() == 0) begin
                if (mismatches < 10)
                    $display("Cycle %0d: unexpected result sensor %0d dist %0d meas %0b acc %0b",
                             cycle_count, m_data.sensor, m_data.distance_mm,
                             m_data.measured, m_data.accepted);
                mismatches++;
            end else begin
                want = expected_results.pop_front();
                if (m_data.sensor !== want.sensor ||
                    m_data.distance_mm !== want.distance_mm ||
                    m_data.measured !== want.measured ||
                    m_data.accepted !== want.accepted) begin
                    // Fields in order: sensor, distance, measured, accepted.
                    if (mismatches < 10)
                        $display("Cycle %0d: expected %0d/%0d/%0b/%0b, got %0d/%0d/%0b/%0b",
                                 cycle_count, want.sensor, want.distance_mm,
                                 want.measured, want.accepted, m_data.sensor,
                                 m_data.distance_mm, m_data.measured, m_data.accepted);
                    mismatches++;
                end
            end
        end
    end

    // Work out the result of one echo edge and advance the channel state.
    function automatic ere_out_t predict_echo_result(input ere_in_t req);
        ere_out_t res;
        logic [TIME_W-1:0] elapsed;
        longint unsigned scaled;
        logic [DIST_W-1:0] reading;
        logic [31:0] weight;
        logic [31:0] mix;
        int unsigned ch;
        ch = req.channel;
        res = '0;
        res.sensor = req.channel;
        if (ch < NSENS) begin
            if (!armed_q[ch]) begin
                start_q[ch] = req.time_us;
                armed_q[ch] = 1'b1;
            end else begin
                // Elapsed time wraps; round half up, then saturate.
                elapsed = req.time_us - start_q[ch];
                scaled = elapsed;
                scaled = (scaled * half_speed_cfg + 32768) >> 16;
                reading = (scaled > 65535) ? 16'hFFFF : scaled[15:0];
                res.measured = 1'b1;
                pulses_measured++;
                if (reading <= max_range_cfg) begin
                    weight = (alpha_cfg > ALPHA_ONE) ? ALPHA_ONE : alpha_cfg;
                    mix = reading * weight + filtered_q[ch] * (ALPHA_ONE - weight) + 128;
                    filtered_q[ch] = mix[23:8];
                    res.accepted = 1'b1;
                    readings_accepted++;
                end
                armed_q[ch] = 1'b0;
            end
            res.distance_mm = filtered_q[ch];
        end
        return res;
    endfunction

    // Sender idles between bursts of random length.
    task automatic pace_sender();
        int gap;
        if (steady_flow)
            return;
        if (burst_left > 0) begin
            burst_left--;
            return;
        end
        burst_left = $urandom_range(0, 12);
        gap = $urandom_range(1, 9);
        s_valid <= 1'b0;
        repeat (gap) @(posedge aclk);
    endtask

    // Present one echo edge and hold it until the ranger takes it.
    task automatic send_edge(input logic [CH_W-1:0] channel, input logic [TIME_W-1:0] stamp);
        ere_in_t req;
        req.channel = channel;
        req.time_us = stamp;
        s_data <= req;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        expected_results.push_back(predict_echo_result(req));
        items_sent++;
        pace_sender();
    endtask

    // Stop sending until every result is back and the datapath has drained.
    task automatic wait_quiet();
        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] value);
        cfg_index <= index;
        cfg_wdata <= value;
        cfg_wr_en <= 1'b1;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        case (index)
            REG_HALF_SPEED: half_speed_cfg = value;
            REG_MAX_RANGE: max_range_cfg = value;
            REG_ALPHA: alpha_cfg = value[ALPHA_W-1:0];
            default: ;
        endcase
        config_writes++;
    endtask

    // Random edge: mostly pulses whose length lands near the range limit.
    task automatic send_random_edge();
        int unsigned ch;
        int pick;
        longint unsigned span;
        logic [31:0] delta;
        logic [TIME_W-1:0] stamp;
        if ($urandom_range(0, 99) < 5) begin
            send_edge(SPARE_CHANNEL, $urandom);
            return;
        end
        ch = $urandom_range(0, NSENS - 1);
        if (half_speed_cfg == 0) begin
            span = 50000;
        end else begin
            span = max_range_cfg;
            span = (span << 16) / half_speed_cfg;
        end
        if (span > 32'h7FFF_FFFF)
            span = 32'h7FFF_FFFF;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            delta = $urandom_range(0, 2 * span);
        else if (pick < 70)
            delta = (span < 3) ? $urandom_range(0, 6) : span + $urandom_range(0, 6) - 3;
        else if (pick < 85)
            delta = $urandom_range(0, 255);
        else
            delta = $urandom;
        stamp = chan_stamp[ch] + delta;
        chan_stamp[ch] = stamp;
        send_edge(ch, stamp);
    endtask

    // Default registers: arm and measure on every channel, one reading too far.
    task automatic test_default_ranging();
        send_edge(2'd0, 32'd1000);
        send_edge(2'd1, 32'd5000);
        send_edge(2'd0, 32'd1000 + 32'd11662);
        send_edge(2'd1, 32'd5000 + 32'd23325);
        send_edge(2'd2, 32'd100);
        send_edge(2'd2, 32'd100 + 32'd30000);
    endtask

    // A zero timestamp arms like any other, and elapsed time wraps.
    task automatic test_zero_and_wrap();
        send_edge(2'd0, 32'd0);
        send_edge(2'd0, 32'hFFFF_FFFF);
        send_edge(2'd1, 32'hFFFF_FFF0);
        send_edge(2'd1, 32'h0000_0100);
    endtask

    // The unused channel leaves every sensor alone.
    task automatic test_unused_channel();
        send_edge(SPARE_CHANNEL, 32'hFFFF_FFFF);
        send_edge(2'd0, 32'd500);
        send_edge(SPARE_CHANNEL, 32'd0);
        send_edge(2'd0, 32'd600);
    endtask

    // Register extremes, alpha above one, and a write to the unused index.
    task automatic test_register_extremes();
        wait_quiet();
        write_register(REG_HALF_SPEED, 16'hFFFF);
        write_register(REG_MAX_RANGE, 16'hFFFF);
        write_register(REG_ALPHA, 16'hFFFF);
        write_register(REG_UNUSED, 16'h0000);
        // Saturated reading is accepted at the widest range.
        send_edge(2'd0, 32'd1);
        send_edge(2'd0, 32'd0);
        wait_quiet();
        write_register(REG_ALPHA, 16'd0);
        write_register(REG_HALF_SPEED, 16'd0);
        write_register(REG_MAX_RANGE, 16'd0);
        // Zero reading at zero range passes, but zero alpha holds the filter.
        send_edge(2'd0, 32'd7);
        send_edge(2'd0, 32'd12345);
        wait_quiet();
        write_register(REG_ALPHA, 16'd256);
        send_edge(2'd0, 32'd40);
        send_edge(2'd0, 32'd90000);
    endtask

    // Random phases, each under its own register setting.
    task automatic test_random_traffic();
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            wait_quiet();
            case ($urandom_range(0, 4))
                0: write_register(REG_HALF_SPEED, 16'd0);
                1: write_register(REG_HALF_SPEED, 16'hFFFF);
                2: write_register(REG_HALF_SPEED, HALF_SPEED_RESET);
                default: write_register(REG_HALF_SPEED, $urandom_range(1, 65535));
            endcase
            case ($urandom_range(0, 4))
                0: write_register(REG_MAX_RANGE, 16'd0);
                1: write_register(REG_MAX_RANGE, 16'hFFFF);
                2: write_register(REG_MAX_RANGE, MAX_RANGE_RESET);
                default: write_register(REG_MAX_RANGE, $urandom_range(0, 65535));
            endcase
            // Upper data bits land outside the 9-bit alpha register.
            case ($urandom_range(0, 5))
                0: write_register(REG_ALPHA, 16'd0);
                1: write_register(REG_ALPHA, 16'd256);
                2: write_register(REG_ALPHA, $urandom_range(257, 511));
                3: write_register(REG_ALPHA, $urandom_range(0, 65535));
                default: write_register(REG_ALPHA, $urandom_range(0, 255));
            endcase
            if ($urandom_range(0, 4) == 0)
                write_register(REG_UNUSED, $urandom_range(0, 65535));
            steady_flow <= (phase % 4 == 3);
            repeat (EDGES_PER_PHASE) begin
                send_random_edge();
                if ($urandom_range(0, 199) == 0)
                    wait_quiet();
            end
        end
    endtask

    initial begin
        half_speed_cfg = HALF_SPEED_RESET;
        max_range_cfg = MAX_RANGE_RESET;
        alpha_cfg = ALPHA_RESET;
        for (int i = 0; i < NSENS; i++) begin
            armed_q[i] = 1'b0;
            start_q[i] = '0;
            filtered_q[i] = '0;
            chan_stamp[i] = $urandom;
        end
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_default_ranging();
        test_zero_and_wrap();
        test_unused_channel();
        test_register_extremes();
        test_random_traffic();
        wait_quiet();

        $display("Covered %0d echo edges over %0d register writes; %0d results checked.",
                 items_sent, config_writes, results_checked);
        $display("%0d pulses measured, %0d readings within range, %0d mismatches.",
                 pulses_measured, readings_accepted, mismatches);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("ultrasonic_echo_ranger_tb OK");
        else
            $display("ultrasonic_echo_ranger_tb NOT OK");
        $finish;
    end

endmodule
